@@ rtl/text_console_char_writer_top_macros.svh @@
// Assertion macros for the text console writer.
// Included by the top level; no other dependencies.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define TCCW_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("text console check failed");

// Next-cycle implication, disabled during reset
`define TCCW_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("text console check failed");

`else

`define TCCW_ASSERT_SAME(label, clk, rst, cond, expr)
`define TCCW_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

@@ rtl/tccw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
package tccw_pkg;

   // Default screen geometry
   localparam int unsigned DEFAULT_COLUMNS = 80;
   localparam int unsigned DEFAULT_ROWS    = 50;

   // Cell and character codes
   localparam logic [15:0] BLANK_CELL     = 16'h0F20;
   localparam logic [7:0]  ATTR_RESET     = 8'h0F;
   localparam logic [7:0]  CODE_BACKSPACE = 8'd8;
   localparam logic [7:0]  CODE_NEWLINE   = 8'd10;

   // Request commands
   localparam logic CMD_PUT   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [11:0] cursor_position;
      logic [5:0]  cursor_line;
      logic [6:0]  cursor_column;
      logic        scrolled;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;       // latch incoming request
      logic exec;         // apply request to cursor and store
      logic sweep_start;  // restart the store sweep
      logic sweep_step;   // advance the store sweep one cell
      logic rsp_load;     // load the response register
   } tccw_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_clear;     // held request is a clear
      logic scroll;       // held request scrolls the screen
      logic sweep_last;   // sweep is at the last cell
      logic rsp_free;     // response register can take a new result
   } tccw_status_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DONE
   } ctrl_state_type;

endpackage

@@ rtl/tccw_ctrl.sv @@
// Controller state machine for the text console writer.
// Depends on tccw_pkg; drives the datapath through tccw_cmd_type.
module tccw_ctrl
   import tccw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  tccw_status_type status,
   output logic            req_ready,
   output tccw_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_BOOT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.is_clear || status.scroll) state_in = ST_SWEEP;
            else state_in = ST_DONE;
         end
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_BOOT;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_BOOT: begin
            cmd.sweep_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_EXEC: begin
            cmd.exec        = 1'b1;
            cmd.sweep_start = status.is_clear || status.scroll;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/tccw_datapath.sv @@
// Datapath for the text console writer: cursor, screen store, sweep, result.
// Depends on tccw_pkg; steered by tccw_ctrl through tccw_cmd_type.
module tccw_datapath
   import tccw_pkg::*;
#(
   parameter int unsigned SCREEN_COLUMNS = DEFAULT_COLUMNS,
   parameter int unsigned SCREEN_ROWS    = DEFAULT_ROWS
) (
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_data,
   input  logic            csr_valid,
   input  logic [7:0]      csr_data,
   input  logic            rsp_ready,
   input  tccw_cmd_type    cmd,
   output tccw_status_type status,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   localparam int unsigned CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
   localparam int unsigned SRC_W      = ADDR_W + 1;
   localparam int unsigned LAST_START = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

   // Held request and architectural state
   req_type     req_ff;
   logic [5:0]  row_ff;
   logic [6:0]  col_ff;
   logic        scrolled_ff;
   logic [7:0]  attr_ff;

   // Sweep state and write pipeline
   logic [ADDR_W-1:0] sweep_ff;
   logic              copy_mode_ff;
   logic              wr_valid_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic              wr_copy_ff;
   logic [15:0]       rd_data_ff;

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Screen store
   logic [15:0] screen_mem [CELL_COUNT];

   logic              is_clear;
   logic              is_bs;
   logic              is_nl;
   logic [5:0]        bs_row;
   logic [6:0]        bs_col;
   logic [7:0]        col_inc;
   logic              at_end;
   logic              last_row;
   logic              scroll_need;
   logic [5:0]        row_in;
   logic [6:0]        col_in;
   logic [5:0]        cell_row;
   logic [6:0]        cell_col;
   logic [ADDR_W-1:0] cell_addr;
   logic [15:0]       cell_data;
   logic              cell_write;
   logic              below_last;
   logic [SRC_W-1:0]  src_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;
   logic [12:0]       pos_full;

   // Request decode
   assign is_clear = (req_ff.command == CMD_CLEAR);
   assign is_bs    = (req_ff.char_code == CODE_BACKSPACE);
   assign is_nl    = (req_ff.char_code == CODE_NEWLINE);
   assign col_inc  = {1'b0, col_ff} + 8'd1;
   assign at_end   = (col_inc == 8'(SCREEN_COLUMNS));
   assign last_row = (row_ff == 6'(SCREEN_ROWS - 1));

   // Backspace target: previous column, or last column of previous row
   always_comb begin
      bs_row = row_ff;
      bs_col = col_ff;
      if (col_ff != 7'd0) begin
         bs_col = col_ff - 7'd1;
      end else if (row_ff != 6'd0) begin
         bs_row = row_ff - 6'd1;
         bs_col = 7'(SCREEN_COLUMNS - 1);
      end
   end

   assign scroll_need = !is_clear && !is_bs && (is_nl || at_end) && last_row;

   // Cursor after this request
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      priority if (is_clear) begin
         row_in = 6'd0;
         col_in = 7'd0;
      end else if (is_bs) begin
         row_in = bs_row;
         col_in = bs_col;
      end else if (is_nl || at_end) begin
         row_in = last_row ? row_ff : row_ff + 6'd1;
         col_in = 7'd0;
      end else begin
         col_in = col_inc[6:0];
      end
   end

   // Cell touched by a put: backspace blanks the new spot, other codes but newline write here
   assign cell_row   = is_bs ? bs_row : row_ff;
   assign cell_col   = is_bs ? bs_col : col_ff;
   assign cell_addr  = ADDR_W'(cell_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(cell_col);
   assign cell_data  = is_bs ? BLANK_CELL : {attr_ff, req_ff.char_code};
   assign cell_write = cmd.exec && !is_clear && !is_nl;

   // Sweep source: one row below, only while copying
   assign below_last = (sweep_ff < ADDR_W'(LAST_START));
   assign src_wide   = SRC_W'(sweep_ff) + SRC_W'(SCREEN_COLUMNS);
   assign rd_addr    = (copy_mode_ff && below_last) ? src_wide[ADDR_W-1:0] : '0;

   // Store write port: sweep pipeline first, then character writes
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cell_addr;
      mem_wdata = cell_data;
      priority if (wr_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = wr_copy_ff ? rd_data_ff : BLANK_CELL;
      end else if (cell_write) begin
         mem_we = 1'b1;
      end
   end

   // Screen store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[rd_addr];
   end

   // Held request
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // Cursor, scroll flag, attribute
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= 6'd0;
         col_ff      <= 7'd0;
         scrolled_ff <= 1'b0;
         attr_ff     <= ATTR_RESET;
      end else begin
         if (cmd.exec) begin
            row_ff      <= row_in;
            col_ff      <= col_in;
            scrolled_ff <= scroll_need;
         end
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
      end
   end

   // Sweep counter and write pipeline; reset starts a blanking pass
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         copy_mode_ff <= 1'b0;
         wr_valid_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_start) begin
            sweep_ff     <= '0;
            copy_mode_ff <= !is_clear;
         end else if (cmd.sweep_step) begin
            sweep_ff <= sweep_ff + ADDR_W'(1);
         end
         wr_valid_ff <= cmd.sweep_step;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= sweep_ff;
      wr_copy_ff <= copy_mode_ff && below_last;
   end

   // Response register
   assign pos_full = 13'(row_ff) * 13'(SCREEN_COLUMNS) + 13'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.cursor_position <= pos_full[11:0];
         rsp_ff.cursor_line     <= row_ff;
         rsp_ff.cursor_column   <= col_ff;
         rsp_ff.scrolled        <= scrolled_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status back to the controller
   assign status.is_clear   = is_clear;
   assign status.scroll     = scroll_need;
   assign status.sweep_last = (sweep_ff == ADDR_W'(CELL_COUNT - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

@@ rtl/text_console_char_writer_top.sv @@
// Channel   | ports                          | carries
// ----------+--------------------------------+-------------------------------
// request   | req_valid, req_ready, req_data | command, char_code
// response  | rsp_valid, rsp_ready, rsp_data | cursor position, line, column, scrolled
// csr write | csr_valid, csr_ready, csr_data | text attribute byte
//
// Put character, newline, backspace: the request passes EXEC, then DONE loads the
// response and the controller returns to IDLE for the next request. Scroll and clear:
// a SWEEP state first runs over all SCREEN_COLUMNS*SCREEN_ROWS cells (4000 at 80x50).
// After reset a blanking pass over all SCREEN_COLUMNS*SCREEN_ROWS cells runs with
// req_ready low; csr writes are always taken.
// A stalled response holds only the load step; one more request may run meanwhile.
//
// Top level of the text console writer: controller plus datapath.
// Depends on tccw_pkg, tccw_ctrl, tccw_datapath and the assertion macro header.
`include "text_console_char_writer_top_macros.svh"

module text_console_char_writer_top
   import tccw_pkg::*;
#(
   parameter int unsigned SCREEN_COLUMNS = DEFAULT_COLUMNS,
   parameter int unsigned SCREEN_ROWS    = DEFAULT_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   tccw_cmd_type    ctrl_cmd;
   tccw_status_type dp_status;

   // Attribute register takes a write any cycle
   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (dp_status),
      .req_ready (req_ready),
      .cmd       (ctrl_cmd)
   );

   tccw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // One request at a time: busy right after acceptance
   `TCCW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // Reported cursor stays on the screen
   `TCCW_ASSERT_SAME(a_cursor_on_screen, clock, reset, rsp_valid, (rsp_data.cursor_line < SCREEN_ROWS) && (rsp_data.cursor_column < SCREEN_COLUMNS))

   // A scroll leaves the cursor on the bottom row
   `TCCW_ASSERT_SAME(a_scroll_bottom_row, clock, reset, rsp_valid && rsp_data.scrolled, rsp_data.cursor_line == 6'(SCREEN_ROWS - 1))

   // Response load never overwrites a result still waiting
   `TCCW_ASSERT_SAME(a_load_when_free, clock, reset, ctrl_cmd.rsp_load, !rsp_valid || rsp_ready)

endmodule

@@ tb/sv/tb_text_console_char_writer_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the text console character writer.
// Depends on tccw_pkg and text_console_char_writer_top; the cursor tracker below predicts
// each response from the accepted requests.
module tb_text_console_char_writer_top;
   import tccw_pkg::*;

   localparam int unsigned COLS          = DEFAULT_COLUMNS;
   localparam int unsigned ROWS          = DEFAULT_ROWS;
   localparam int unsigned CYCLE_LIMIT   = 20_000_000;
   localparam int unsigned PRESSURE_HOLD = 300;
   localparam int unsigned TAIL_CYCLES   = 20;

   // Cursor tracker: predicts cursor and scroll flag, queues them, checks responses.
   // The cell store never reaches the response, so only the cursor is modeled.
   class cursor_tracker;
      int unsigned row;
      int unsigned col;
      logic [7:0]  attribute;
      rsp_type     expected_q[$];
      int unsigned errors;
      int unsigned requests;
      int unsigned compared;
      int unsigned scrolls;
      int unsigned clears;
      int unsigned wraps;

      function new();
         row       = 0;
         col       = 0;
         attribute = ATTR_RESET;
      endfunction

      function void set_attribute(logic [7:0] value);
         attribute = value;
      endfunction

      // Apply one accepted request to the cursor and queue the expected response
      function void note_request(req_type item);
         rsp_type exp_rsp;
         logic    rolled;
         rolled = 1'b0;
         requests++;
         if (item.command == CMD_CLEAR) begin
            row = 0;
            col = 0;
            clears++;
         end else begin
            if (item.char_code == CODE_BACKSPACE) begin
               if (col > 0) begin
                  col--;
               end else if (row > 0) begin
                  row--;
                  col = COLS - 1;
                  wraps++;
               end
            end else if (item.char_code == CODE_NEWLINE) begin
               row++;
               col = 0;
            end else begin
               col++;
            end
            // line end wrap
            if (col >= COLS) begin
               col = 0;
               row++;
               wraps++;
            end
            // past the last row: screen moves up one row
            if (row >= ROWS) begin
               row    = ROWS - 1;
               rolled = 1'b1;
               scrolls++;
            end
         end
         exp_rsp.cursor_position = 12'((row * COLS + col) & 32'hFFF);
         exp_rsp.cursor_line     = 6'(row);
         exp_rsp.cursor_column   = 7'(col);
         exp_rsp.scrolled        = rolled;
         expected_q.push_back(exp_rsp);
      endfunction

      // Compare one accepted response with the oldest expectation
      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("response with no request pending: %p", got);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         compared++;
         if (got.cursor_position !== exp_rsp.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   exp_rsp.cursor_position, got.cursor_position);
            errors++;
         end
         if (got.cursor_line !== exp_rsp.cursor_line) begin
            $error("cursor_line: expected %0d, got %0d", exp_rsp.cursor_line, got.cursor_line);
            errors++;
         end
         if (got.cursor_column !== exp_rsp.cursor_column) begin
            $error("cursor_column: expected %0d, got %0d",
                   exp_rsp.cursor_column, got.cursor_column);
            errors++;
         end
         if (got.scrolled !== exp_rsp.scrolled) begin
            $error("scrolled: expected %0b, got %0b", exp_rsp.scrolled, got.scrolled);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   cursor_tracker tracker = new();
   bit            quiet;
   int unsigned   press_count;
   int unsigned   press_seen;
   int unsigned   hold_left;
   int unsigned   cycles;

   text_console_char_writer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      quiet       = 1'b0;
      press_count = 0;
      press_seen  = 0;
      hold_left   = 0;
      cycles      = 0;
   end

   always #10 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   // Response side: random stalls, plus one long hold-off on request from the stimulus
   always @(negedge clock) begin
      if (press_seen != press_count) begin
         press_seen = press_count;
         hold_left  = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
   end

   // Response check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_response(rsp_data);
   end

   // Offer one request after a gap; returns at the edge that accepts it
   task automatic send_request(req_type item, int unsigned gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(item);
   endtask

   task automatic put_char(logic [7:0] code);
      req_type item;
      item.command   = CMD_PUT;
      item.char_code = code;
      send_request(item, pick_gap());
   endtask

   task automatic send_clear(logic [7:0] code);
      req_type item;
      item.command   = CMD_CLEAR;
      item.char_code = code;
      send_request(item, pick_gap());
   endtask

   function automatic logic [7:0] printable_code();
      logic [7:0] code;
      do code = 8'($urandom_range(0, 255));
      while (code == CODE_BACKSPACE || code == CODE_NEWLINE);
      return code;
   endfunction

   // Attribute write; only issued while no request is in flight
   task automatic write_attribute(logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_attribute(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid and wait for every response of the phase
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Random text: lines of varied length with stray backspaces, runs of blank
   // lines to reach the bottom row, and the odd clear
   task automatic random_text(int unsigned count);
      int unsigned sent;
      int unsigned kind;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 3) begin
            send_clear(8'($urandom_range(0, 255)));
            sent++;
         end else if (kind < 13) begin
            len = $urandom_range(5, 30);
            repeat (len) put_char(CODE_NEWLINE);
            sent += len;
         end else begin
            if (kind < 60)      len = $urandom_range(0, 4);
            else if (kind < 90) len = $urandom_range(5, 20);
            else                len = $urandom_range(60, 90);
            repeat (len) begin
               if ($urandom_range(0, 9) == 0) put_char(CODE_BACKSPACE);
               else put_char(printable_code());
            end
            sent += len;
            if ($urandom_range(0, 99) < 85) begin
               put_char(CODE_NEWLINE);
               sent++;
            end
         end
      end
   endtask

   // Main sequence
   initial begin
      req_type item;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      write_attribute(8'h00);

      // Directed: field extremes, backspace at home and at line start, wraps, clears
      send_clear(8'hFF);
      put_char(8'h41);
      put_char(CODE_BACKSPACE);
      put_char(CODE_BACKSPACE);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h80);
      put_char(8'h7F);
      put_char(CODE_NEWLINE);
      put_char(CODE_BACKSPACE);
      put_char(8'h55);
      put_char(8'hAA);
      put_char(8'h20);
      put_char(8'h09);
      put_char(8'h0B);
      put_char(CODE_NEWLINE);
      put_char(CODE_NEWLINE);
      put_char(CODE_BACKSPACE);
      put_char(CODE_BACKSPACE);
      send_clear(8'h00);
      send_clear(CODE_NEWLINE);
      put_char(8'h01);
      send_clear(CODE_BACKSPACE);
      drain();

      write_attribute(8'hFF);

      // Back-pressure: response side holds off while requests keep coming
      press_count++;
      repeat (14) begin
         item.command   = CMD_PUT;
         item.char_code = printable_code();
         send_request(item, 0);
      end
      random_text(140);
      drain();

      // No idling on either side for this phase
      write_attribute(8'($urandom_range(1, 254)));
      quiet = 1'b1;
      random_text(140);
      drain();
      quiet = 1'b0;

      write_attribute(ATTR_RESET);
      random_text(140);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d clears, %0d scrolls, %0d cursor wraps.",
               tracker.requests, tracker.clears, tracker.scrolls, tracker.wraps);
      $display("Compared %0d responses across four attribute settings; %0d mismatches.",
               tracker.compared, tracker.errors);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_ctrl.sv
rtl/tccw_datapath.sv
rtl/text_console_char_writer_top.sv
tb/sv/tb_text_console_char_writer_top.sv
